### sv/rgb888_coverage_span_blend_unit_defines.svh
// Assertion macros shared by the span blend unit's modules.
`ifndef RGB888_COVERAGE_SPAN_BLEND_UNIT_DEFINES_SVH
`define RGB888_COVERAGE_SPAN_BLEND_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising edge of the clock outside reset.
`define RCSB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge outside reset.
`define RCSB_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RCSB_ASSERT(lbl, clk, rst, prop, msg)
`define RCSB_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

### sv/rcsb_pkg.sv
// Types, constants and the channel mix function of the span blend unit.
package rcsb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ALPHA = 8'd3;

  localparam logic [7:0] ALPHA_RESET = 8'hFF;
  localparam logic [7:0] FULL_ALPHA  = 8'hFF;
  localparam logic [15:0] ROUND_BIAS = 16'h0080;

  // Pixel classes decided from the alpha.
  localparam logic [1:0] CLS_KEEP = 2'd0;
  localparam logic [1:0] CLS_FILL = 2'd1;
  localparam logic [1:0] CLS_MIX  = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } dest_t;

  typedef struct packed {
    logic [31:0] sum;
    dest_t       dest;
  } entry_t;

  function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] d,
                                             input logic [7:0] a);
    logic [15:0] acc;
    acc = 16'(c) * 16'(a) + 16'(FULL_ALPHA - a) * 16'(d) + ROUND_BIAS;
    return acc[15:8];
  endfunction

endpackage

### sv/rcsb_if.sv
// Channel interfaces of the span blend unit: pixel input, result output, config writes.
interface rcsb_pixel_if;
  logic        valid;
  logic        ready;
  logic        line_start;
  logic [31:0] start_coverage;
  logic signed [31:0] step_delta;
  logic [7:0]  dest_blue;
  logic [7:0]  dest_green;
  logic [7:0]  dest_red;

  modport source (output valid, line_start, start_coverage, step_delta,
                  dest_blue, dest_green, dest_red, input ready);
  modport sink (input valid, line_start, start_coverage, step_delta,
                dest_blue, dest_green, dest_red, output ready);
endinterface

interface rcsb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       out_pad;

  modport source (output valid, out_blue, out_green, out_red, out_pad, input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_pad, output ready);
endinterface

interface rcsb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rcsb_pkg::CFG_IDX_W-1:0]  index;
  logic [rcsb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/rcsb_queue.sv
// Small first-in first-out queue between the front and back parts.
`include "rgb888_coverage_span_blend_unit_defines.svh"

module rcsb_queue #(
  parameter int DEPTH = rcsb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcsb_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output rcsb_pkg::entry_t rd_entry,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rcsb_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RCSB_NEVER(a_no_overflow, clk, rst, push && full, "queue written while full")
  `RCSB_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count did not grow on a lone write")

endmodule

### sv/rcsb_front.sv
// Front part: accepts pixels and runs the wrapping coverage sum.
module rcsb_front (
  input  logic              clk,
  input  logic              rst,
  rcsb_pixel_if.sink        pixel,
  input  logic              queue_full,
  output logic              push,
  output rcsb_pkg::entry_t  entry
);

  logic [31:0] coverage_sum;
  logic [31:0] coverage_sum_next;
  logic [31:0] base;

  assign pixel.ready = !queue_full;
  assign push        = pixel.valid && pixel.ready;

  always_comb begin
    base              = pixel.line_start ? pixel.start_coverage : coverage_sum;
    coverage_sum_next = base + $unsigned(pixel.step_delta);
    entry.sum         = coverage_sum_next;
    entry.dest.blue   = pixel.dest_blue;
    entry.dest.green  = pixel.dest_green;
    entry.dest.red    = pixel.dest_red;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coverage_sum <= '0;
    end else if (push) begin
      coverage_sum <= coverage_sum_next;
    end
  end

endmodule

### sv/rcsb_back.sv
// Back part: alpha multiply and classification, then the channel blend and output register.
`include "rgb888_coverage_span_blend_unit_defines.svh"

module rcsb_back (
  input  logic             clk,
  input  logic             rst,
  input  rcsb_pkg::color_t color,
  input  logic             queue_empty,
  input  rcsb_pkg::entry_t entry,
  output logic             pop,
  rcsb_result_if.source    result
);

  logic        out_en;
  logic        s1_en;
  logic [31:0] prod;
  logic [15:0] alpha_wide;
  logic [1:0]  cls;

  logic            s1_valid;
  logic [1:0]      s1_cls;
  logic [7:0]      s1_alpha;
  rcsb_pkg::dest_t s1_dest;

  logic       out_valid;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;

  assign out_en = !out_valid || result.ready;
  assign s1_en  = !s1_valid || out_en;
  assign pop    = !queue_empty && s1_en;

  always_comb begin
    prod       = {24'b0, color.alpha} * {8'b0, entry.sum[31:8]};
    alpha_wide = prod[31:16];
    if (alpha_wide == '0) begin
      cls = rcsb_pkg::CLS_KEEP;
    end else if (alpha_wide >= 16'(rcsb_pkg::FULL_ALPHA)) begin
      cls = rcsb_pkg::CLS_FILL;
    end else begin
      cls = rcsb_pkg::CLS_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cls   <= cls;
      s1_alpha <= alpha_wide[7:0];
      s1_dest  <= entry.dest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid) begin
      case (s1_cls)
        rcsb_pkg::CLS_FILL: begin
          out_blue  <= color.blue;
          out_green <= color.green;
          out_red   <= color.red;
        end
        rcsb_pkg::CLS_MIX: begin
          out_blue  <= rcsb_pkg::mix_channel(color.blue, s1_dest.blue, s1_alpha);
          out_green <= rcsb_pkg::mix_channel(color.green, s1_dest.green, s1_alpha);
          out_red   <= rcsb_pkg::mix_channel(color.red, s1_dest.red, s1_alpha);
        end
        default: begin
          out_blue  <= s1_dest.blue;
          out_green <= s1_dest.green;
          out_red   <= s1_dest.red;
        end
      endcase
    end
  end

  assign result.valid     = out_valid;
  assign result.out_blue  = out_blue;
  assign result.out_green = out_green;
  assign result.out_red   = out_red;
  assign result.out_pad   = 1'b0;

  `RCSB_ASSERT(a_s1_hold, clk, rst, (s1_valid && !out_en) |=> (s1_valid && $stable(s1_dest) && $stable(s1_alpha)), "blend stage changed while stalled")
  `RCSB_NEVER(a_pop_blocked, clk, rst, pop && s1_valid && !out_en, "queue read while the blend stage is stalled")

endmodule

### sv/rgb888_coverage_span_blend_unit.sv
// Top level of the antialiased span blend unit: config registers, front, queue and back.
// This unit paints one antialiased scanline of a constant fill color into BGRX pixels.
// Each pixel transaction on the pixel channel carries the destination bytes, a signed
// coverage delta and, on the first pixel of a span, a starting coverage. The front part
// keeps a 32-bit wrapping coverage sum, fed back to itself through an add, and accepts one
// pixel per clock cycle while the queue has room. Accepted pixels wait in a short queue,
// so the front keeps taking pixels while the result side is stalled, until the queue
// fills. The back part forms alpha = (color_alpha * (sum >> 8)) >> 16 in one stage and the
// per-channel blend in the next; a pixel passes through the queue, the alpha stage and the
// output register, and results follow at one per cycle when nothing stalls. Zero alpha
// returns the destination bytes, an alpha of 255 or more returns the
// fill color, and anything in between blends with rounding. The pad byte always reads
// zero. The four color registers are written on the config channel, which is always
// ready; indexes beyond the last register are ignored. Write them only while no pixel is
// in flight. After reset the color is black with full opacity and the coverage sum is 0.
module rgb888_coverage_span_blend_unit #(
  parameter int QUEUE_DEPTH = rcsb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  rcsb_cfg_if.sink      cfg,
  rcsb_pixel_if.sink    pixel,
  rcsb_result_if.source result
);

  rcsb_pkg::color_t color;
  rcsb_pkg::entry_t wr_entry;
  rcsb_pkg::entry_t rd_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // The config channel never stalls; a write lands at the edge of its transaction.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color.red   <= '0;
      color.green <= '0;
      color.blue  <= '0;
      color.alpha <= rcsb_pkg::ALPHA_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rcsb_pkg::REG_COLOR_RED:   color.red   <= cfg.data;
        rcsb_pkg::REG_COLOR_GREEN: color.green <= cfg.data;
        rcsb_pkg::REG_COLOR_BLUE:  color.blue  <= cfg.data;
        rcsb_pkg::REG_COLOR_ALPHA: color.alpha <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // The front accepts pixels and updates the coverage sum as they arrive.
  rcsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .queue_full (full),
    .push       (push),
    .entry      (wr_entry)
  );

  // The queue decouples pixel acceptance from the result side.
  rcsb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (empty)
  );

  // The back computes the alpha, blends the channels and holds the result.
  rcsb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .color       (color),
    .queue_empty (empty),
    .entry       (rd_entry),
    .pop         (pop),
    .result      (result)
  );

endmodule
